// ===== rtl/assert_macros.svh =====
// shared assertion macro
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge while out of reset
`define DSB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dsb assertion failed");

`endif

// ===== rtl/dsb_pkg.sv =====
`timescale 1ns / 1ps
package dsb_pkg;

  localparam int unsigned CHAN_BITS    = 8;
  localparam int unsigned PIXEL_BITS   = 32;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned DIV_STEPS    = 8;
  localparam logic [CHAN_BITS-1:0] ALPHA_MAX = 8'hFF;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_AREA_X       = 3'd0,
    CFG_AREA_Y       = 3'd1,
    CFG_AREA_WIDTH   = 3'd2,
    CFG_AREA_HEIGHT  = 3'd3,
    CFG_FADE_RADIUS  = 3'd4,
    CFG_SHADOW_COLOR = 3'd5
  } cfg_idx_e;

  // exact x / 255 for x up to 255 * 255 plus one
  function automatic logic [CHAN_BITS-1:0] div255(input logic [16:0] x);
    logic [17:0] s;
    s = 18'(x) + 18'd1 + 18'(x >> 8);
    return s[15:8];
  endfunction

endpackage

// ===== rtl/dsb_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dsb_front import dsb_pkg::*; #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [COORD_BITS-1:0]    pixel_x_i,
  input  logic [COORD_BITS-1:0]    pixel_y_i,
  input  logic [PIXEL_BITS-1:0]    background_pixel_i,
  input  logic [COORD_BITS-1:0]    area_x_i,
  input  logic [COORD_BITS-1:0]    area_y_i,
  input  logic [COORD_BITS:0]      area_width_i,
  input  logic [COORD_BITS:0]      area_height_i,
  input  logic [2*RADIUS_BITS-1:0] r2_i,
  output logic                     push_o,
  output logic                     push_wb_o,
  output logic [PIXEL_BITS-1:0]    push_bg_o,
  output logic [2*RADIUS_BITS-1:0] push_diff_o
);

  localparam int unsigned GW = COORD_BITS + 1;
  localparam int unsigned SW = 2 * GW;
  localparam int unsigned DW = SW + 1;
  localparam int unsigned RW = 2 * RADIUS_BITS;
  localparam int unsigned CW = (DW > RW) ? DW : RW;

  logic          v1_q, v2_q, v3_q;
  logic [GW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [SW-1:0] sx_q, sy_q;
  logic [DW-1:0] dist_q;
  logic [PIXEL_BITS-1:0] bg1_q, bg2_q, bg3_q;
  logic [GW-1:0] hx, hy, px, py;
  logic [CW-1:0] dist_w, r2_w;

  assign px = GW'(pixel_x_i);
  assign py = GW'(pixel_y_i);
  assign hx = GW'(area_x_i) + area_width_i;
  assign hy = GW'(area_y_i) + area_height_i;

  always_comb begin
    if (px < GW'(area_x_i)) begin
      dx_d = GW'(area_x_i) - px;
    end else if (px >= hx) begin
      dx_d = px - hx;
    end else begin
      dx_d = '0;
    end
    if (py < GW'(area_y_i)) begin
      dy_d = GW'(area_y_i) - py;
    end else if (py >= hy) begin
      dy_d = py - hy;
    end else begin
      dy_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    bg1_q  <= background_pixel_i;
    sx_q   <= dx_q * dx_q;
    sy_q   <= dy_q * dy_q;
    bg2_q  <= bg1_q;
    dist_q <= DW'(sx_q) + DW'(sy_q);
    bg3_q  <= bg2_q;
  end

  assign dist_w      = CW'(dist_q);
  assign r2_w        = CW'(r2_i);
  assign push_o      = v3_q;
  assign push_wb_o   = dist_w < r2_w;
  assign push_bg_o   = bg3_q;
  // only meaningful when the pixel is inside the radius
  assign push_diff_o = RW'(r2_w - dist_w);

  `DSB_ASSERT(a_front_latency, clk_i, rst_ni, accept_i |=> ##2 push_o)

endmodule

// ===== rtl/dsb_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dsb_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] head_o,
  output logic             full_o
);

  localparam int unsigned DEPTH = 2;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;

  assign valid_o = count_q != 2'd0;
  assign full_o  = count_q == 2'(DEPTH);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i && valid_o) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i && valid_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  `DSB_ASSERT(a_fifo_no_overflow, clk_i, rst_ni, (push_i && full_o) |-> pop_i)

endmodule

// ===== rtl/dsb_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dsb_back import dsb_pkg::*; #(
  parameter int unsigned RADIUS_BITS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic                     wb_i,
  input  logic [PIXEL_BITS-1:0]    bg_i,
  input  logic [2*RADIUS_BITS-1:0] diff_i,
  input  logic [2*RADIUS_BITS-1:0] r2_i,
  input  logic [PIXEL_BITS-1:0]    shadow_color_i,
  output logic                     done_o,
  output logic                     write_back_o,
  output logic [PIXEL_BITS-1:0]    result_pixel_o
);

  localparam int unsigned RW = 2 * RADIUS_BITS;
  localparam int unsigned NW = CHAN_BITS + RW;

  logic [CHAN_BITS-1:0] sh_a;
  assign sh_a = shadow_color_i[31:24];

  // stage 0 holds the numerator, stages 1..8 retire one quotient bit each
  logic                  v_q   [DIV_STEPS+1];
  logic                  wb_q  [DIV_STEPS+1];
  logic [PIXEL_BITS-1:0] bg_q  [DIV_STEPS+1];
  logic [NW-1:0]         rem_q [DIV_STEPS+1];
  logic [CHAN_BITS-1:0]  quo_q [DIV_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_q[0]  <= wb_i;
    bg_q[0]  <= bg_i;
    rem_q[0] <= NW'(sh_a) * NW'(diff_i);
    quo_q[0] <= '0;
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    localparam int unsigned BIT = DIV_STEPS - 1 - s;
    logic [NW-1:0] sub;
    logic          ge;
    assign sub = NW'(r2_i) << BIT;
    assign ge  = rem_q[s] >= sub;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s+1] <= 1'b0;
      end else begin
        v_q[s+1] <= v_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      wb_q[s+1]  <= wb_q[s];
      bg_q[s+1]  <= bg_q[s];
      rem_q[s+1] <= ge ? rem_q[s] - sub : rem_q[s];
      quo_q[s+1] <= quo_q[s] | (CHAN_BITS'(ge) << BIT);
    end
  end

  logic [CHAN_BITS-1:0] a, inv;
  assign a   = quo_q[DIV_STEPS];
  assign inv = ALPHA_MAX - a;

  // blend products
  logic                  bv_q, bwb_q, bzero_q, bfull_q;
  logic [PIXEL_BITS-1:0] bbg_q;
  logic [16:0]           pr_q, pg_q, pb_q, pa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= 1'b0;
    end else begin
      bv_q <= v_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    bwb_q   <= wb_q[DIV_STEPS];
    bbg_q   <= bg_q[DIV_STEPS];
    bzero_q <= a == '0;
    bfull_q <= a == ALPHA_MAX;
    pr_q <= 17'(bg_q[DIV_STEPS][23:16]) * 17'(inv) + 17'(shadow_color_i[23:16]) * 17'(a);
    pg_q <= 17'(bg_q[DIV_STEPS][15:8]) * 17'(inv) + 17'(shadow_color_i[15:8]) * 17'(a);
    pb_q <= 17'(bg_q[DIV_STEPS][7:0]) * 17'(inv) + 17'(shadow_color_i[7:0]) * 17'(a);
    pa_q <= 17'(ALPHA_MAX - bg_q[DIV_STEPS][31:24]) * 17'(a);
  end

  logic                  done_q, wbo_q;
  logic [PIXEL_BITS-1:0] pix_d, pix_q;

  always_comb begin
    if (!bwb_q || bzero_q) begin
      pix_d = bbg_q;
    end else if (bfull_q) begin
      pix_d = {ALPHA_MAX, shadow_color_i[23:0]};
    end else begin
      pix_d = {bbg_q[31:24] + div255(pa_q), div255(pr_q), div255(pg_q), div255(pb_q)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= bv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    wbo_q <= bwb_q;
    pix_q <= pix_d;
  end

  assign done_o         = done_q;
  assign write_back_o   = wbo_q;
  assign result_pixel_o = pix_q;

  `DSB_ASSERT(a_alpha_bound, clk_i, rst_ni, (v_q[DIV_STEPS] && wb_q[DIV_STEPS]) |-> (a <= sh_a))

endmodule

// ===== rtl/drop_shadow_pixel_blend_core.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake               payload
// pixel     in         start_i / busy_o        pixel_x_i, pixel_y_i, background_pixel_i
// result    out        done_o strobe           write_back_o, result_pixel_o
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// one pixel per cycle sustained; from start to done each pixel passes through
// three distance stages, one queue slot, a multiply, eight divider steps and two blend stages
// the divider retires one alpha bit per stage, which sets the depth
// reset clears control and config only; config registers reset to zero
// the result cannot be stalled, so busy_o only rises if the queue ever fills
module drop_shadow_pixel_blend_core import dsb_pkg::*; #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned RADIUS_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [COORD_BITS-1:0]   pixel_x_i,
  input  logic [COORD_BITS-1:0]   pixel_y_i,
  input  logic [PIXEL_BITS-1:0]   background_pixel_i,
  output logic                    done_o,
  output logic                    write_back_o,
  output logic [PIXEL_BITS-1:0]   result_pixel_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [31:0]             cfg_data_i
);

  localparam int unsigned RW = 2 * RADIUS_BITS;
  localparam int unsigned QW = 1 + PIXEL_BITS + RW;

  logic [COORD_BITS-1:0]  area_x_q, area_y_q;
  logic [COORD_BITS:0]    area_width_q, area_height_q;
  logic [RADIUS_BITS-1:0] fade_radius_q;
  logic [PIXEL_BITS-1:0]  shadow_color_q;
  logic [RW-1:0]          r2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_x_q       <= '0;
      area_y_q       <= '0;
      area_width_q   <= '0;
      area_height_q  <= '0;
      fade_radius_q  <= '0;
      shadow_color_q <= '0;
      r2_q           <= '0;
    end else begin
      r2_q <= RW'(fade_radius_q) * RW'(fade_radius_q);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_AREA_X:       area_x_q       <= cfg_data_i[COORD_BITS-1:0];
          CFG_AREA_Y:       area_y_q       <= cfg_data_i[COORD_BITS-1:0];
          CFG_AREA_WIDTH:   area_width_q   <= cfg_data_i[COORD_BITS:0];
          CFG_AREA_HEIGHT:  area_height_q  <= cfg_data_i[COORD_BITS:0];
          CFG_FADE_RADIUS:  fade_radius_q  <= cfg_data_i[RADIUS_BITS-1:0];
          CFG_SHADOW_COLOR: shadow_color_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  logic                  accept, push, push_wb, q_valid, q_full;
  logic [PIXEL_BITS-1:0] push_bg;
  logic [RW-1:0]         push_diff;
  logic [QW-1:0]         q_head;

  assign busy_o = q_full;
  assign accept = start_i && !busy_o;

  dsb_front #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (accept),
    .pixel_x_i         (pixel_x_i),
    .pixel_y_i         (pixel_y_i),
    .background_pixel_i(background_pixel_i),
    .area_x_i          (area_x_q),
    .area_y_i          (area_y_q),
    .area_width_i      (area_width_q),
    .area_height_i     (area_height_q),
    .r2_i              (r2_q),
    .push_o            (push),
    .push_wb_o         (push_wb),
    .push_bg_o         (push_bg),
    .push_diff_o       (push_diff)
  );

  dsb_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_wb, push_bg, push_diff}),
    .pop_i      (q_valid),
    .valid_o    (q_valid),
    .head_o     (q_head),
    .full_o     (q_full)
  );

  dsb_back #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .wb_i          (q_head[QW-1]),
    .bg_i          (q_head[QW-2 -: PIXEL_BITS]),
    .diff_i        (q_head[RW-1:0]),
    .r2_i          (r2_q),
    .shadow_color_i(shadow_color_q),
    .done_o        (done_o),
    .write_back_o  (write_back_o),
    .result_pixel_o(result_pixel_o)
  );

endmodule
